/* hdl/qvc_pkg.sv */
// Shared types and constants for the quadrilateral validity check.
`timescale 1ns / 1ps
`default_nettype none
package qvc_pkg;

    localparam int unsigned RANGE_MAX = 100;
    localparam int unsigned IN_W      = 10;
    localparam int unsigned CW        = 7;   // coordinate bits once in range
    localparam int unsigned DW        = 8;   // signed difference width
    localparam int unsigned PW        = 16;  // signed product / cross product width
    localparam int unsigned NXP       = 9;   // cross products evaluated per item

    typedef enum logic [2:0] {
        ST_VALID    = 3'd0,
        ST_RANGE    = 3'd1,
        ST_COINCIDE = 3'd2,
        ST_CROSS    = 3'd3,
        ST_COLINEAR = 3'd4
    } t_status;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_xp_flags;

endpackage
`default_nettype wire

/* hdl/qvc_xprod.sv */
// Two-stage pipelined cross product with sign and zero flags.
`timescale 1ns / 1ps
`default_nettype none
module qvc_xprod
    import qvc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic signed [DW-1:0] i_ux,
    input  wire logic signed [DW-1:0] i_uy,
    input  wire logic signed [DW-1:0] i_vx,
    input  wire logic signed [DW-1:0] i_vy,
    output t_xp_flags                 o_flags
);

    logic signed [PW-1:0] r_p0;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] n_diff;
    t_xp_flags            r_flags;

    assign n_diff = r_p0 - r_p1;

    always_ff @(posedge i_clk) begin
        r_p0          <= PW'(i_ux) * PW'(i_vy);
        r_p1          <= PW'(i_uy) * PW'(i_vx);
        r_flags.neg   <= n_diff[PW-1];
        r_flags.zero  <= (n_diff == '0);
    end

    assign o_flags = r_flags;

endmodule
`default_nettype wire

/* hdl/quadrilateral_validity_check.sv */
// Top level: pipelined quadrilateral validity check, vertex A at the origin.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  item in   | start / busy       | i_b_x i_b_y i_c_x i_c_y i_d_x i_d_y (10b)
//  result    | o_valid (strobe)   | o_status (3b)
//
// Four register stages: range/coincide/operands, products, cross product
// flags, status priority. One item per cycle.
// busy is always low: the pipeline never stalls and every result is shown
// for exactly one cycle. Synchronous active-low reset clears the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module quadrilateral_validity_check
    import qvc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [IN_W-1:0] i_b_x,
    input  wire logic [IN_W-1:0] i_b_y,
    input  wire logic [IN_W-1:0] i_c_x,
    input  wire logic [IN_W-1:0] i_c_y,
    input  wire logic [IN_W-1:0] i_d_x,
    input  wire logic [IN_W-1:0] i_d_y,
    output logic                 o_valid,
    output logic [2:0]           o_status
);

    localparam logic [IN_W-1:0] LIM = IN_W'(RANGE_MAX);

    // stage 1 combinational
    logic signed [DW-1:0] bx, by, cx, cy, dx, dy;
    logic signed [DW-1:0] n_ux [NXP];
    logic signed [DW-1:0] n_uy [NXP];
    logic signed [DW-1:0] n_vx [NXP];
    logic signed [DW-1:0] n_vy [NXP];
    logic                 n_range;
    logic                 n_coin;

    logic signed [DW-1:0] r_ux [NXP];
    logic signed [DW-1:0] r_uy [NXP];
    logic signed [DW-1:0] r_vx [NXP];
    logic signed [DW-1:0] r_vy [NXP];
    logic                 r1_valid, r2_valid, r3_valid;
    logic                 r1_range, r2_range, r3_range;
    logic                 r1_coin,  r2_coin,  r3_coin;
    t_xp_flags            xp [NXP];

    logic                 n_cross1, n_cross2, n_colin;
    t_status              n_status;
    logic                 r_valid;
    t_status              r_status;

    assign busy = 1'b0;

    assign bx = signed'({1'b0, i_b_x[CW-1:0]});
    assign by = signed'({1'b0, i_b_y[CW-1:0]});
    assign cx = signed'({1'b0, i_c_x[CW-1:0]});
    assign cy = signed'({1'b0, i_c_y[CW-1:0]});
    assign dx = signed'({1'b0, i_d_x[CW-1:0]});
    assign dy = signed'({1'b0, i_d_y[CW-1:0]});

    assign n_range = (i_b_x > LIM) || (i_b_y > LIM) || (i_c_x > LIM) ||
                     (i_c_y > LIM) || (i_d_x > LIM) || (i_d_y > LIM);

    assign n_coin = (bx == '0 && by == '0) || (cx == '0 && cy == '0) ||
                    (dx == '0 && dy == '0) || (bx == cx && by == cy) ||
                    (bx == dx && by == dy) || (cx == dx && cy == dy);

    always_comb begin
        // edge CD against AB
        n_ux[0] = cx;       n_uy[0] = cy;       n_vx[0] = bx;       n_vy[0] = by;
        n_ux[1] = dx;       n_uy[1] = dy;       n_vx[1] = bx;       n_vy[1] = by;
        n_ux[2] = -cx;      n_uy[2] = -cy;      n_vx[2] = dx - cx;  n_vy[2] = dy - cy;
        n_ux[3] = bx - cx;  n_uy[3] = by - cy;  n_vx[3] = dx - cx;  n_vy[3] = dy - cy;
        // edge AD against CB
        n_ux[4] = -cx;      n_uy[4] = -cy;      n_vx[4] = bx - cx;  n_vy[4] = by - cy;
        n_ux[5] = dx - cx;  n_uy[5] = dy - cy;  n_vx[5] = bx - cx;  n_vy[5] = by - cy;
        n_ux[6] = cx;       n_uy[6] = cy;       n_vx[6] = dx;       n_vy[6] = dy;
        n_ux[7] = bx;       n_uy[7] = by;       n_vx[7] = dx;       n_vy[7] = dy;
        // triple BCD
        n_ux[8] = cx - bx;  n_uy[8] = cy - by;  n_vx[8] = dx - bx;  n_vy[8] = dy - by;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_valid  <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux     <= n_ux;
        r_uy     <= n_uy;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r1_range <= n_range;
        r1_coin  <= n_coin;
        r2_range <= r1_range;
        r2_coin  <= r1_coin;
        r3_range <= r2_range;
        r3_coin  <= r2_coin;
        r_status <= n_status;
    end

    for (genvar g = 0; g < NXP; g++) begin : g_xp
        qvc_xprod u_xprod (
            .i_clk   (i_clk),
            .i_ux    (r_ux[g]),
            .i_uy    (r_uy[g]),
            .i_vx    (r_vx[g]),
            .i_vy    (r_vy[g]),
            .o_flags (xp[g])
        );
    end

    function automatic logic opp_sign(input t_xp_flags a, input t_xp_flags b);
        opp_sign = !a.zero && !b.zero && (a.neg != b.neg);
    endfunction

    assign n_cross1 = opp_sign(xp[0], xp[1]) && opp_sign(xp[2], xp[3]);
    assign n_cross2 = opp_sign(xp[4], xp[5]) && opp_sign(xp[6], xp[7]);
    // triple ABC uses the same product as xp[0] up to sign
    assign n_colin  = xp[0].zero || xp[8].zero || xp[6].zero || xp[7].zero;

    always_comb begin
        if (r3_range) begin
            n_status = ST_RANGE;
        end else if (r3_coin) begin
            n_status = ST_COINCIDE;
        end else if (n_cross1 || n_cross2) begin
            n_status = ST_CROSS;
        end else if (n_colin) begin
            n_status = ST_COLINEAR;
        end else begin
            n_status = ST_VALID;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 4))
        else $error("result strobe without an item four cycles earlier");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_COLINEAR))
        else $error("status code out of range");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && r3_range) |=> (o_valid && o_status == ST_RANGE))
        else $error("range failure not reported first");

endmodule
`default_nettype wire

/* tb/quadrilateral_validity_check_test.sv */
// Testbench for quadrilateral_validity_check: directed and random vertex sets vs. a predictor.
`timescale 1ns / 1ps
module quadrilateral_validity_check_test;
    import qvc_pkg::*;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [IN_W-1:0] i_b_x;
    logic [IN_W-1:0] i_b_y;
    logic [IN_W-1:0] i_c_x;
    logic [IN_W-1:0] i_c_y;
    logic [IN_W-1:0] i_d_x;
    logic [IN_W-1:0] i_d_y;
    logic            o_valid;
    logic [2:0]      o_status;

    t_status     exp_fifo[64];
    logic [5:0]  exp_wr_ptr = '0;
    logic [5:0]  exp_rd_ptr = '0;
    int unsigned exp_count = 0;
    int unsigned status_seen[5];
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned n_errors;

    quadrilateral_validity_check u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_b_x    (i_b_x),
        .i_b_y    (i_b_y),
        .i_c_x    (i_c_x),
        .i_c_y    (i_c_y),
        .i_d_x    (i_d_x),
        .i_d_y    (i_d_y),
        .o_valid  (o_valid),
        .o_status (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint cross_z(input longint ux, input longint uy,
                                       input longint vx, input longint vy);
        return ux * vy - uy * vx;
    endfunction

    // proper crossing of P0-P1 and P2-P3; touching does not count
    function automatic bit segments_cross(input longint p0x, input longint p0y,
                                          input longint p1x, input longint p1y,
                                          input longint p2x, input longint p2y,
                                          input longint p3x, input longint p3y);
        longint s1, s2, t1, t2;
        s1 = cross_z(p2x - p0x, p2y - p0y, p1x - p0x, p1y - p0y);
        s2 = cross_z(p3x - p0x, p3y - p0y, p1x - p0x, p1y - p0y);
        t1 = cross_z(p0x - p2x, p0y - p2y, p3x - p2x, p3y - p2y);
        t2 = cross_z(p1x - p2x, p1y - p2y, p3x - p2x, p3y - p2y);
        return (s1 * s2 < 0) && (t1 * t2 < 0);
    endfunction

    function automatic t_status judge_quad(input logic [IN_W-1:0] bx_in,
                                           input logic [IN_W-1:0] by_in,
                                           input logic [IN_W-1:0] cx_in,
                                           input logic [IN_W-1:0] cy_in,
                                           input logic [IN_W-1:0] dx_in,
                                           input logic [IN_W-1:0] dy_in);
        longint bx, by, cx, cy, dx, dy, lim;
        bx  = longint'(bx_in);
        by  = longint'(by_in);
        cx  = longint'(cx_in);
        cy  = longint'(cy_in);
        dx  = longint'(dx_in);
        dy  = longint'(dy_in);
        lim = longint'(RANGE_MAX);
        if (bx > lim || by > lim || cx > lim || cy > lim || dx > lim || dy > lim)
            return ST_RANGE;
        if ((bx == 0 && by == 0) || (cx == 0 && cy == 0) || (dx == 0 && dy == 0) ||
            (bx == cx && by == cy) || (bx == dx && by == dy) || (cx == dx && cy == dy))
            return ST_COINCIDE;
        if (segments_cross(0, 0, bx, by, cx, cy, dx, dy) ||
            segments_cross(cx, cy, bx, by, 0, 0, dx, dy))
            return ST_CROSS;
        if (cross_z(bx, by, cx, cy) == 0 ||
            cross_z(cx - bx, cy - by, dx - bx, dy - by) == 0 ||
            cross_z(cx, cy, dx, dy) == 0 ||
            cross_z(bx, by, dx, dy) == 0)
            return ST_COLINEAR;
        return ST_VALID;
    endfunction

    // expectation is queued before the output check so any latency works
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n) begin
            if (start && !busy) begin
                exp_fifo[exp_wr_ptr] = judge_quad(i_b_x, i_b_y, i_c_x, i_c_y,
                                                  i_d_x, i_d_y);
                exp_wr_ptr++;
                exp_count++;
            end
            if (o_valid) begin
                if (exp_count == 0) begin
                    $error("status: unexpected result %0d with no item pending", o_status);
                    n_errors++;
                end else begin
                    want = exp_fifo[exp_rd_ptr];
                    exp_rd_ptr++;
                    exp_count--;
                    results_checked++;
                    if (want <= ST_COLINEAR)
                        status_seen[want]++;
                    if (o_status !== want) begin
                        $error("status mismatch: expected %0d, actual %0d", want, o_status);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic send_item(input logic [IN_W-1:0] bx, input logic [IN_W-1:0] by,
                             input logic [IN_W-1:0] cx, input logic [IN_W-1:0] cy,
                             input logic [IN_W-1:0] dx, input logic [IN_W-1:0] dy,
                             input int gap_pct);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_b_x <= bx;
        i_b_y <= by;
        i_c_x <= cx;
        i_c_y <= cy;
        i_d_x <= dx;
        i_d_y <= dy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic test_range_limits();
        send_item(10'd1023, 10'd0,  10'd10, 10'd10, 10'd0,  10'd10, 27);
        send_item(10'd101,  10'd0,  10'd10, 10'd10, 10'd0,  10'd10, 27);
        send_item(10'd10,   10'd101, 10'd10, 10'd10, 10'd0, 10'd10, 27);
        send_item(10'd10,   10'd0,  10'd101, 10'd10, 10'd0, 10'd10, 27);
        send_item(10'd10,   10'd0,  10'd10, 10'd101, 10'd0, 10'd10, 27);
        send_item(10'd10,   10'd0,  10'd10, 10'd10, 10'd101, 10'd10, 27);
        send_item(10'd10,   10'd0,  10'd10, 10'd10, 10'd0,  10'd1023, 27);
        // several failures at once: range wins
        send_item(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 27);
    endtask

    task automatic test_vertex_coincidence();
        send_item(10'd0,  10'd0,  10'd10, 10'd10, 10'd0,  10'd10, 27);
        send_item(10'd10, 10'd0,  10'd0,  10'd0,  10'd0,  10'd10, 27);
        send_item(10'd10, 10'd0,  10'd10, 10'd10, 10'd0,  10'd0,  27);
        send_item(10'd10, 10'd10, 10'd10, 10'd10, 10'd0,  10'd10, 27);
        send_item(10'd10, 10'd0,  10'd10, 10'd10, 10'd10, 10'd0,  27);
        send_item(10'd10, 10'd0,  10'd0,  10'd10, 10'd0,  10'd10, 27);
    endtask

    task automatic test_edge_crossing();
        send_item(10'd10, 10'd10, 10'd10, 10'd0,  10'd0,  10'd10, 27);
        send_item(10'd10, 10'd0,  10'd0,  10'd10, 10'd10, 10'd10, 27);
        // D touches AB: not a proper crossing
        send_item(10'd10, 10'd10, 10'd10, 10'd0,  10'd5,  10'd5,  27);
    endtask

    task automatic test_colinear_and_valid();
        send_item(10'd5,   10'd5,   10'd10,  10'd10,  10'd0,   10'd10,  27);
        send_item(10'd10,  10'd0,   10'd10,  10'd10,  10'd10,  10'd20,  27);
        send_item(10'd10,  10'd0,   10'd10,  10'd10,  10'd20,  10'd20,  27);
        send_item(10'd100, 10'd0,   10'd100, 10'd100, 10'd0,   10'd100, 27);
        send_item(10'd1,   10'd0,   10'd1,   10'd1,   10'd0,   10'd1,   27);
        send_item(10'd10,  10'd0,   10'd10,  10'd10,  10'd0,   10'd10,  27);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int count);
        logic [IN_W-1:0] v[6];
        int mode;
        int a, b, m, k, src;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(99);
            if (mode < 10) begin
                foreach (v[i]) v[i] = IN_W'($urandom_range(1023));
            end else if (mode < 35) begin
                foreach (v[i]) v[i] = IN_W'($urandom_range(6));
            end else if (mode < 42) begin
                foreach (v[i]) begin
                    case ($urandom_range(5))
                        0: v[i] = 10'd0;
                        1: v[i] = 10'd1;
                        2: v[i] = 10'd99;
                        3: v[i] = 10'd100;
                        4: v[i] = 10'd101;
                        default: v[i] = IN_W'($urandom_range(100));
                    endcase
                end
            end else begin
                foreach (v[i]) v[i] = IN_W'($urandom_range(100));
                if (mode < 55) begin
                    // force a coincidence: a zero vertex or a copied one
                    k = $urandom_range(2);
                    src = (k + $urandom_range(1, 2)) % 3;
                    if ($urandom_range(1)) begin
                        v[2*k]   = 10'd0;
                        v[2*k+1] = 10'd0;
                    end else begin
                        v[2*k]   = v[2*src];
                        v[2*k+1] = v[2*src+1];
                    end
                end else if (mode < 68) begin
                    // put two vertices on one line through the origin
                    a = $urandom_range(25);
                    b = $urandom_range(25);
                    m = $urandom_range(2, 4);
                    k = $urandom_range(2);
                    v[2*k]   = IN_W'(a);
                    v[2*k+1] = IN_W'(b);
                    src = (k + 1) % 3;
                    v[2*src]   = IN_W'(a * m);
                    v[2*src+1] = IN_W'(b * m);
                end
            end
            send_item(v[0], v[1], v[2], v[3], v[4], v[5], gap_pct);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_b_x   = '0;
        i_b_y   = '0;
        i_c_x   = '0;
        i_c_y   = '0;
        i_d_x   = '0;
        i_d_y   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_limits();
        test_vertex_coincidence();
        test_edge_crossing();
        test_colinear_and_valid();
        test_random_traffic(27, 383);
        test_random_traffic(88, 383);
        test_random_traffic(0, 384);
        start <= 1'b0;

        while (exp_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results", items_sent, results_checked);
        $display("Status mix: valid %0d, range %0d, coincide %0d, cross %0d, colinear %0d",
                 status_seen[ST_VALID], status_seen[ST_RANGE], status_seen[ST_COINCIDE],
                 status_seen[ST_CROSS], status_seen[ST_COLINEAR]);
        if (n_errors == 0 && results_checked == items_sent) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/qvc_pkg.sv
hdl/qvc_xprod.sv
hdl/quadrilateral_validity_check.sv
tb/quadrilateral_validity_check_test.sv
